### sv/nmdb_pkg.sv
// nmdb_pkg: widths, codes, item types and rounding helpers for the
// normal map detail blend unit; used by every module of the block.
// no dependencies
package nmdb_pkg;

  localparam int CH_BITS = 16;
  localparam logic [CH_BITS-1:0] CH_MAX = '1;
  localparam logic [CH_BITS-1:0] CH_MID = {1'b1, {(CH_BITS-1){1'b0}}};

  // fixed point widths, all vectors carry 16 fraction bits
  localparam int EXP_W  = 18;  // expanded channel, -1.0 .. 1.0
  localparam int SCL_W  = 16;  // detail scale, 12 fraction bits
  localparam int SCP_W  = 34;  // channel times scale
  localparam int DET_W  = 21;  // scaled detail component and rounded products
  localparam int PRD_W  = 39;  // base times detail product
  localparam int VEC_W  = 23;  // blended component
  localparam int SQ_W   = 44;  // sum of squares
  localparam int ROOT_W = 22;  // integer square root
  localparam int REM_W  = 46;  // square root remainder and trial
  localparam int NUM_W  = 40;  // unorm numerator
  localparam int DEN_W  = 23;  // unorm denominator, twice the length
  localparam int QB     = 16;  // quotient bits

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] MODE_LINEAR   = 3'd0;
  localparam logic [2:0] MODE_DERIV    = 3'd1;
  localparam logic [2:0] MODE_UDN      = 3'd2;
  localparam logic [2:0] MODE_REORIENT = 3'd3;
  localparam logic [2:0] MODE_WHITEOUT = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETAIL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA = 2'd2;

  localparam logic [2:0] RST_BLEND_MODE = MODE_WHITEOUT;
  localparam logic [SCL_W-1:0] RST_DETAIL_SCALE = 16'd4096;

  typedef logic signed [EXP_W-1:0] exp_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    exp_t bx;
    exp_t by;
    exp_t bz;
    exp_t dx;
    exp_t dy;
    exp_t dz;
    logic [2:0] mode;
    logic [CH_BITS-1:0] alpha;
  } item_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
    logic [SQ_W-1:0] sumsq;
    logic [CH_BITS-1:0] alpha;
  } blend_t;

  // 2c/M - 1 in q16, rounded half away from zero; for M = 65535 the
  // division reduces to |2c - M| plus one when that is at least half scale
  function automatic exp_t expand(input logic [CH_BITS-1:0] c);
    logic signed [EXP_W-1:0] v;
    logic [CH_BITS-1:0] a;
    logic [CH_BITS:0] e;
    v = $signed({1'b0, c, 1'b0}) - $signed({2'b00, CH_MAX});
    a = v[EXP_W-1] ? CH_BITS'(-v) : v[CH_BITS-1:0];
    e = {1'b0, a} + {{CH_BITS{1'b0}}, a[CH_BITS-1]};
    expand = v[EXP_W-1] ? -$signed({1'b0, e}) : $signed({1'b0, e});
  endfunction

  // divide by 4096, round half away from zero
  function automatic det_t round_q12(input logic signed [SCP_W-1:0] p);
    logic [SCP_W-1:0] mag;
    logic [SCP_W-1:0] m;
    logic [DET_W-1:0] r;
    mag = p[SCP_W-1] ? SCP_W'(-p) : p;
    m = mag + SCP_W'(2048);
    r = m[DET_W+11:12];
    round_q12 = p[SCP_W-1] ? -$signed(r) : $signed(r);
  endfunction

  // divide by 65536, round half away from zero
  function automatic det_t round_q16(input logic signed [PRD_W-1:0] p);
    logic [PRD_W-1:0] mag;
    logic [PRD_W-1:0] m;
    logic [DET_W-1:0] r;
    mag = p[PRD_W-1] ? PRD_W'(-p) : p;
    m = mag + PRD_W'(32768);
    r = m[DET_W+15:16];
    round_q16 = p[PRD_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### sv/nmdb_front.sv
// nmdb_front: input register, channel expansion and mode decode
// depends on nmdb_pkg
module nmdb_front import nmdb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [CH_BITS-1:0] base_x,
  input  logic [CH_BITS-1:0] base_y,
  input  logic [CH_BITS-1:0] base_z,
  input  logic [CH_BITS-1:0] base_alpha,
  input  logic [CH_BITS-1:0] detail_x,
  input  logic [CH_BITS-1:0] detail_y,
  input  logic [CH_BITS-1:0] detail_z,
  input  logic [2:0]         blend_mode,
  input  logic               base_has_alpha,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_data
);

  logic  v_r, v_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign full   = v_r && q_full;
  assign take   = push && !full;
  assign q_push = v_r && !q_full;
  assign q_data = item_r;

  always_comb begin
    v_nxt = take ? 1'b1 : (q_push ? 1'b0 : v_r);
    item_nxt.bx = expand(base_x);
    item_nxt.by = expand(base_y);
    item_nxt.bz = expand(base_z);
    item_nxt.dx = expand(detail_x);
    item_nxt.dy = expand(detail_y);
    item_nxt.dz = expand(detail_z);
    // unused codes fall back to whiteout
    item_nxt.mode  = (blend_mode > MODE_WHITEOUT) ? MODE_WHITEOUT : blend_mode;
    item_nxt.alpha = base_has_alpha ? base_alpha : CH_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

### sv/nmdb_queue.sv
// nmdb_queue: short flop queue between the front and the arithmetic pipe
// depends on nmdb_pkg
module nmdb_queue import nmdb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t dout
);

  item_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                do_pop;

  assign full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid  = (cnt_r != '0);
  assign dout   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### sv/nmdb_back.sv
// nmdb_back: detail scaling, blend modes and sum of squares, seven stages
// depends on nmdb_pkg
module nmdb_back import nmdb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    q_valid,
  input  item_t                   q_data,
  input  logic signed [SCL_W-1:0] scale,
  output logic                    q_pop,
  output logic                    b_valid,
  output blend_t                  b_data
);

  logic [7:1] v_r;

  // stage 1: detail times scale
  item_t                   it1_r;
  logic signed [SCP_W-1:0] p1_r [3];
  // stage 2: rounded scaled detail
  exp_t             b2_r [3];
  det_t             d2_r [3];
  logic [2:0]       m2_r;
  logic [CH_BITS-1:0] a2_r;
  // stage 3: base by detail products
  logic signed [PRD_W-1:0] pr3_r [3][3];
  exp_t             b3_r [3];
  det_t             d3_r [3];
  logic [2:0]       m3_r;
  logic [CH_BITS-1:0] a3_r;
  // stage 4: rounded products
  det_t             q4_r [3][3];
  exp_t             b4_r [3];
  det_t             d4_r [3];
  logic [2:0]       m4_r;
  logic [CH_BITS-1:0] a4_r;
  // stage 5: blended vector
  vec_t             v5_r [3];
  vec_t             v5_nxt [3];
  logic [CH_BITS-1:0] a5_r;
  // stage 6: squares
  logic [SQ_W-1:0]  s6_r [3];
  vec_t             v6_r [3];
  logic [CH_BITS-1:0] a6_r;
  logic signed [2*VEC_W-1:0] sqf [3];
  // stage 7
  blend_t           o7_r;

  assign q_pop   = adv && q_valid;
  assign b_valid = v_r[7];
  assign b_data  = o7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:1], q_valid};
    end
  end

  always_comb begin
    unique case (m4_r)
      MODE_LINEAR: begin
        v5_nxt[0] = VEC_W'(b4_r[0]) + VEC_W'(d4_r[0]);
        v5_nxt[1] = VEC_W'(b4_r[1]) + VEC_W'(d4_r[1]);
        v5_nxt[2] = VEC_W'(b4_r[2]) + VEC_W'(d4_r[2]);
      end
      MODE_DERIV: begin
        v5_nxt[0] = VEC_W'(q4_r[0][2]) + VEC_W'(q4_r[2][0]);
        v5_nxt[1] = VEC_W'(q4_r[1][2]) + VEC_W'(q4_r[2][1]);
        v5_nxt[2] = VEC_W'(q4_r[2][2]);
      end
      MODE_UDN: begin
        v5_nxt[0] = VEC_W'(b4_r[0]) + VEC_W'(d4_r[0]);
        v5_nxt[1] = VEC_W'(b4_r[1]) + VEC_W'(d4_r[1]);
        v5_nxt[2] = VEC_W'(b4_r[2]);
      end
      MODE_REORIENT: begin
        // basis rows (z, y, -x), (x, z, -y), (x, y, z) weighted by detail
        v5_nxt[0] = VEC_W'(q4_r[2][0]) + VEC_W'(q4_r[0][1]) + VEC_W'(q4_r[0][2]);
        v5_nxt[1] = VEC_W'(q4_r[1][0]) + VEC_W'(q4_r[2][1]) + VEC_W'(q4_r[1][2]);
        v5_nxt[2] = VEC_W'(q4_r[2][2]) - VEC_W'(q4_r[0][0]) - VEC_W'(q4_r[1][1]);
      end
      default: begin
        v5_nxt[0] = VEC_W'(b4_r[0]) + VEC_W'(d4_r[0]);
        v5_nxt[1] = VEC_W'(b4_r[1]) + VEC_W'(d4_r[1]);
        v5_nxt[2] = VEC_W'(q4_r[2][2]);
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      sqf[i] = v5_r[i] * v5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r   <= q_data;
      p1_r[0] <= $signed(q_data.dx) * scale;
      p1_r[1] <= $signed(q_data.dy) * scale;
      p1_r[2] <= $signed(q_data.dz) * scale;

      b2_r[0] <= it1_r.bx;
      b2_r[1] <= it1_r.by;
      b2_r[2] <= it1_r.bz;
      for (int i = 0; i < 3; i++) begin
        d2_r[i] <= round_q12(p1_r[i]);
      end
      m2_r <= it1_r.mode;
      a2_r <= it1_r.alpha;

      for (int b = 0; b < 3; b++) begin
        for (int d = 0; d < 3; d++) begin
          pr3_r[b][d] <= b2_r[b] * d2_r[d];
        end
      end
      b3_r <= b2_r;
      d3_r <= d2_r;
      m3_r <= m2_r;
      a3_r <= a2_r;

      for (int b = 0; b < 3; b++) begin
        for (int d = 0; d < 3; d++) begin
          q4_r[b][d] <= round_q16(pr3_r[b][d]);
        end
      end
      b4_r <= b3_r;
      d4_r <= d3_r;
      m4_r <= m3_r;
      a4_r <= a3_r;

      v5_r <= v5_nxt;
      a5_r <= a4_r;

      for (int i = 0; i < 3; i++) begin
        s6_r[i] <= sqf[i][SQ_W-1:0];
      end
      v6_r <= v5_r;
      a6_r <= a5_r;

      o7_r.x     <= v6_r[0];
      o7_r.y     <= v6_r[1];
      o7_r.z     <= v6_r[2];
      o7_r.sumsq <= s6_r[0] + s6_r[1] + s6_r[2];
      o7_r.alpha <= a6_r;
    end
  end

endmodule

### sv/nmdb_norm.sv
// nmdb_norm: pipelined square root, unorm division per channel and the
// output register; depends on nmdb_pkg
module nmdb_norm import nmdb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               b_valid,
  input  blend_t             b_data,
  output logic               out_valid,
  output logic [CH_BITS-1:0] out_x,
  output logic [CH_BITS-1:0] out_y,
  output logic [CH_BITS-1:0] out_z,
  output logic [CH_BITS-1:0] out_alpha,
  output logic               out_zero_length
);

  // square root stages, one root bit each
  logic               sv_r   [ROOT_W];
  logic [REM_W-1:0]   srem_r [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  vec_t               svec_r [ROOT_W][3];
  logic [CH_BITS-1:0] sal_r  [ROOT_W];

  // numerator stage
  logic               nv_r;
  logic [NUM_W-1:0]   num_r [3];
  logic [DEN_W-1:0]   nden_r;
  logic               nzero_r;
  logic [CH_BITS-1:0] nal_r;

  // division stages, one quotient bit each
  logic               dv_r   [QB];
  logic [NUM_W-1:0]   drem_r [QB][3];
  logic [QB-1:0]      quo_r  [QB][3];
  logic [DEN_W-1:0]   dden_r [QB];
  logic               dzero_r[QB];
  logic [CH_BITS-1:0] dal_r  [QB];

  logic               o_v_r;
  logic [CH_BITS-1:0] ox_r, oy_r, oz_r, oa_r;
  logic               oz_len_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - i;
    logic               v_in;
    logic [REM_W-1:0]   rem_in, trial;
    logic [ROOT_W-1:0]  root_in;
    vec_t               vec_in [3];
    logic [CH_BITS-1:0] al_in;

    if (i == 0) begin : g_first
      assign v_in      = b_valid;
      assign rem_in    = REM_W'(b_data.sumsq);
      assign root_in   = '0;
      assign vec_in[0] = b_data.x;
      assign vec_in[1] = b_data.y;
      assign vec_in[2] = b_data.z;
      assign al_in     = b_data.alpha;
    end else begin : g_next
      assign v_in    = sv_r[i-1];
      assign rem_in  = srem_r[i-1];
      assign root_in = root_r[i-1];
      assign vec_in  = svec_r[i-1];
      assign al_in   = sal_r[i-1];
    end

    // (2r + 2^k) * 2^k with r holding only the bits above k
    assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else if (adv) begin
        sv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          srem_r[i] <= rem_in - trial;
          root_r[i] <= root_in | (ROOT_W'(1) << K);
        end else begin
          srem_r[i] <= rem_in;
          root_r[i] <= root_in;
        end
        svec_r[i] <= vec_in;
        sal_r[i]  <= al_in;
      end
    end
  end

  // numerator m*(v+L)+L and denominator 2L
  logic [ROOT_W-1:0]        len;
  logic                     len_zero;
  logic signed [VEC_W:0]    tsum [3];
  logic [VEC_W:0]           tu   [3];
  logic [NUM_W-1:0]         num_nxt [3];

  assign len      = root_r[ROOT_W-1];
  assign len_zero = (len == '0);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      tsum[l] = $signed({2'b00, len}) + (VEC_W+1)'(svec_r[ROOT_W-1][l]);
      tu[l]   = tsum[l];
      num_nxt[l] = len_zero ? '0 :
                   (NUM_W'(tu[l]) << CH_BITS) - NUM_W'(tu[l]) + NUM_W'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (adv) begin
      nv_r <= sv_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= num_nxt;
      nden_r  <= len_zero ? DEN_W'(1) : {len, 1'b0};
      nzero_r <= len_zero;
      nal_r   <= sal_r[ROOT_W-1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic               v_in;
    logic [NUM_W-1:0]   rem_in [3];
    logic [QB-1:0]      q_in   [3];
    logic [DEN_W-1:0]   den_in;
    logic               zero_in;
    logic [CH_BITS-1:0] al_in;
    logic [NUM_W-1:0]   trial;

    if (j == 0) begin : g_first
      assign v_in    = nv_r;
      assign rem_in  = num_r;
      assign q_in[0] = '0;
      assign q_in[1] = '0;
      assign q_in[2] = '0;
      assign den_in  = nden_r;
      assign zero_in = nzero_r;
      assign al_in   = nal_r;
    end else begin : g_next
      assign v_in    = dv_r[j-1];
      assign rem_in  = drem_r[j-1];
      assign q_in    = quo_r[j-1];
      assign den_in  = dden_r[j-1];
      assign zero_in = dzero_r[j-1];
      assign al_in   = dal_r[j-1];
    end

    assign trial = NUM_W'(den_in) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= trial) begin
            drem_r[j][l] <= rem_in[l] - trial;
            quo_r[j][l]  <= q_in[l] | (QB'(1) << K);
          end else begin
            drem_r[j][l] <= rem_in[l];
            quo_r[j][l]  <= q_in[l];
          end
        end
        dden_r[j]  <= den_in;
        dzero_r[j] <= zero_in;
        dal_r[j]   <= al_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= dv_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r     <= dzero_r[QB-1] ? CH_MID : quo_r[QB-1][0];
      oy_r     <= dzero_r[QB-1] ? CH_MID : quo_r[QB-1][1];
      oz_r     <= dzero_r[QB-1] ? CH_MID : quo_r[QB-1][2];
      oa_r     <= dal_r[QB-1];
      oz_len_r <= dzero_r[QB-1];
    end
  end

  assign out_valid       = o_v_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_alpha       = oa_r;
  assign out_zero_length = oz_len_r;

endmodule

### sv/normal_map_detail_blend_unit.sv
// normal_map_detail_blend_unit: top level of the detail normal blender
// depends on nmdb_pkg, nmdb_front, nmdb_queue, nmdb_back, nmdb_norm
//
// Usage:
//   Input side is a queue: drive the texel fields and raise push; the
//   transaction happens at a clock edge with push high and full low.
//   Result side is a queue: while empty is low the oldest result is on the
//   out_ ports; it is taken at an edge with pop high and empty low.
//   Configuration: cfg_we with cfg_index (0 blend mode, 1 detail scale,
//   2 base alpha pass-through) writes cfg_data at the edge; write only while
//   no texel is in flight.
//   Throughput: one texel per cycle while results are taken. From the input
//   transaction to empty going low a texel passes the queue, the seven
//   blend stages, the 22-stage square root (one root bit per stage), the
//   numerator stage, the 16-stage divider (one quotient bit per stage)
//   and the output register.
//   When pop is held low with a result waiting, the arithmetic pipe
//   freezes; the input register and the 4-entry queue still take up to five
//   more texels before full rises.
//   Reset (rst_n low, synchronous) empties every stage and queue and sets
//   whiteout mode, detail scale 1.0 and alpha one.
module normal_map_detail_blend_unit import nmdb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [CH_BITS-1:0]   in_base_x,
  input  logic [CH_BITS-1:0]   in_base_y,
  input  logic [CH_BITS-1:0]   in_base_z,
  input  logic [CH_BITS-1:0]   in_base_alpha,
  input  logic [CH_BITS-1:0]   in_detail_x,
  input  logic [CH_BITS-1:0]   in_detail_y,
  input  logic [CH_BITS-1:0]   in_detail_z,
  output logic                 empty,
  input  logic                 pop,
  output logic [CH_BITS-1:0]   out_x,
  output logic [CH_BITS-1:0]   out_y,
  output logic [CH_BITS-1:0]   out_z,
  output logic [CH_BITS-1:0]   out_alpha,
  output logic                 out_zero_length,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCL_W-1:0]     cfg_data
);

  logic [2:0]       mode_r;
  logic [SCL_W-1:0] scale_r;
  logic             alpha_en_r;

  logic   q_full, q_push, q_valid, q_pop;
  item_t  q_din, q_dout;
  logic   b_valid;
  blend_t b_data;
  logic   out_valid;
  logic   adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= RST_BLEND_MODE;
      scale_r    <= RST_DETAIL_SCALE;
      alpha_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_MODE:   mode_r     <= cfg_data[2:0];
        CFG_DETAIL_SCALE: scale_r    <= cfg_data;
        CFG_BASE_ALPHA:   alpha_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // arithmetic pipe moves unless a finished result is waiting and pop is low
  assign adv   = !out_valid || pop;
  assign empty = !out_valid;

  nmdb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .base_x         (in_base_x),
    .base_y         (in_base_y),
    .base_z         (in_base_z),
    .base_alpha     (in_base_alpha),
    .detail_x       (in_detail_x),
    .detail_y       (in_detail_y),
    .detail_z       (in_detail_z),
    .blend_mode     (mode_r),
    .base_has_alpha (alpha_en_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_din)
  );

  nmdb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  nmdb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .q_valid (q_valid),
    .q_data  (q_dout),
    .scale   ($signed(scale_r)),
    .q_pop   (q_pop),
    .b_valid (b_valid),
    .b_data  (b_data)
  );

  nmdb_norm u_norm (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .b_valid         (b_valid),
    .b_data          (b_data),
    .out_valid       (out_valid),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_alpha       (out_alpha),
    .out_zero_length (out_zero_length)
  );

endmodule

### sv/nmdb_checker.sv
// nmdb_checker: port-level checks on the detail normal blender, bound to
// the top level; depends on nmdb_pkg
module nmdb_checker import nmdb_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [CH_BITS-1:0]   out_x,
  input logic [CH_BITS-1:0]   out_y,
  input logic [CH_BITS-1:0]   out_z,
  input logic [CH_BITS-1:0]   out_alpha,
  input logic                 out_zero_length
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result visible right after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input blocked right after reset");

  // a waiting result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(out_alpha) && $stable(out_zero_length))
    else $error("waiting result changed before transaction");

  // degenerate vector gives mid-grey
  a_mid_grey: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_zero_length |-> out_x == CH_MID && out_y == CH_MID &&
      out_z == CH_MID)
    else $error("zero length result not mid-grey");

endmodule

bind normal_map_detail_blend_unit nmdb_checker u_nmdb_checker (.*);
